// File: rtl/core/atp_pkg.sv
// Package for the ASCII telegram parser: framing constants, status codes,
// the per-telegram state and end-of-telegram result types.
// No dependencies.
package atp_pkg;

   localparam int MAX_TELEGRAM = 32;
   localparam int HEADER_LEN   = 10;
   localparam int CHECK_LEN    = 3;
   localparam int COUNT_MAX    = 127;
   localparam int END_LEN      = HEADER_LEN + CHECK_LEN;

   localparam logic [7:0] CR_BYTE    = 8'd13;
   localparam logic [7:0] DIGIT_ZERO = 8'h30;
   localparam logic [7:0] DIGIT_NINE = 8'h39;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_MALFORMED = 2'd1;
   localparam logic [1:0] STATUS_CHECKSUM  = 2'd2;
   localparam logic [1:0] STATUS_BOUNDS    = 2'd3;

   typedef struct packed {
      logic [6:0] byte_count;
      logic [7:0] running_sum;
      logic [7:0] tail0;
      logic [7:0] tail1;
      logic [7:0] tail2;
      logic [9:0] address_acc;
      logic [6:0] action_acc;
      logic [9:0] param_acc;
      logic [6:0] length_acc;
      logic       malformed;
   } tg_state_type;

   typedef struct packed {
      logic [9:0] station_addr;
      logic [6:0] action_code;
      logic [9:0] param_index;
      logic [6:0] payload_len;
      logic [9:0] received_checksum;
      logic [1:0] parse_status;
   } end_result_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= DIGIT_ZERO) && (c <= DIGIT_NINE);
   endfunction

endpackage

// File: rtl/core/atp_end_check.sv
// End-of-telegram evaluation: decodes the checksum digits and sets the status.
// Depends on atp_pkg.
module atp_end_check (
   input  atp_pkg::tg_state_type   state,
   output atp_pkg::end_result_type result
);

   logic       chk_digits;
   logic [9:0] chk_value;
   logic [9:0] chk;
   logic [7:0] need_len;
   logic [7:0] avail_len;
   logic       bad;

   always_comb begin
      chk_digits = atp_pkg::is_digit(state.tail0) && atp_pkg::is_digit(state.tail1) &&
                   atp_pkg::is_digit(state.tail2);
      chk_value  = 10'({6'b0, state.tail2[3:0]} * 10'd100) +
                   10'({6'b0, state.tail1[3:0]} * 10'd10) + {6'b0, state.tail0[3:0]};
      chk        = chk_digits ? chk_value : 10'd0;
      need_len   = 8'(atp_pkg::HEADER_LEN) + {1'b0, state.length_acc};
      avail_len  = {1'b0, 7'(state.byte_count - 7'(atp_pkg::CHECK_LEN))};
      bad        = state.malformed || !chk_digits ||
                   (state.byte_count < 7'(atp_pkg::END_LEN)) ||
                   (state.byte_count >= 7'(atp_pkg::MAX_TELEGRAM));

      result.station_addr      = state.address_acc;
      result.action_code       = state.action_acc;
      result.param_index       = state.param_acc;
      result.payload_len       = state.length_acc;
      result.received_checksum = chk;
      if (bad) begin
         result.parse_status = atp_pkg::STATUS_MALFORMED;
      end else if (chk != {2'b0, state.running_sum}) begin
         result.parse_status = atp_pkg::STATUS_CHECKSUM;
      end else if (need_len > avail_len) begin
         result.parse_status = atp_pkg::STATUS_BOUNDS;
      end else begin
         result.parse_status = atp_pkg::STATUS_OK;
      end
   end

endmodule

// File: rtl/core/ascii_telegram_parser.sv
// A result word is registered and appears in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle; a byte is taken while a result waits
// unless the result register is full and stalled.
// Reset (synchronous, active high) clears the telegram state and the result
// valid flag. Depends on atp_pkg and atp_end_check.
module ascii_telegram_parser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_kind,
   output logic [7:0] rsp_data_byte,
   output logic [9:0] rsp_station_addr,
   output logic [6:0] rsp_action_code,
   output logic [9:0] rsp_param_index,
   output logic [6:0] rsp_payload_len,
   output logic [9:0] rsp_received_checksum,
   output logic [1:0] rsp_parse_status
);

   atp_pkg::tg_state_type   state_ff, state_in;
   atp_pkg::end_result_type end_result;
   atp_pkg::end_result_type fields_ff, fields_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    kind_ff, kind_in;
   logic [7:0]              data_ff, data_in;

   logic       accept;
   logic       is_cr;
   logic       retire_en;
   logic [6:0] pos;
   logic [6:0] data_pos;
   logic [7:0] leaving;
   logic [3:0] digit;
   logic       emit;

   atp_end_check u_end_check (
      .state  (state_ff),
      .result (end_result)
   );

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign is_cr     = (req_rx_byte == atp_pkg::CR_BYTE);

   always_comb begin
      leaving   = state_ff.tail2;
      digit     = leaving[3:0];
      retire_en = (state_ff.byte_count >= 7'(atp_pkg::CHECK_LEN)) &&
                  (state_ff.byte_count != 7'(atp_pkg::COUNT_MAX));
      pos       = 7'(state_ff.byte_count - 7'(atp_pkg::CHECK_LEN));
      data_pos  = 7'(pos - 7'(atp_pkg::HEADER_LEN));
      emit      = retire_en && (pos >= 7'(atp_pkg::HEADER_LEN)) &&
                  (data_pos < state_ff.length_acc);

      state_in = state_ff;
      if (is_cr) begin
         state_in = '0;
      end else begin
         if (retire_en) begin
            state_in.running_sum = 8'(state_ff.running_sum + leaving);
            if (pos < 7'(atp_pkg::HEADER_LEN)) begin
               if (!atp_pkg::is_digit(leaving)) begin
                  state_in.malformed = 1'b1;
               end else if (pos < 7'd3) begin
                  state_in.address_acc = 10'(state_ff.address_acc * 10'd10) +
                                         {6'b0, digit};
               end else if (pos < 7'd5) begin
                  state_in.action_acc = 7'(state_ff.action_acc * 7'd10) + {3'b0, digit};
               end else if (pos < 7'd8) begin
                  state_in.param_acc = 10'(state_ff.param_acc * 10'd10) + {6'b0, digit};
               end else begin
                  state_in.length_acc = 7'(state_ff.length_acc * 7'd10) + {3'b0, digit};
               end
            end
         end
         state_in.tail2 = state_ff.tail1;
         state_in.tail1 = state_ff.tail0;
         state_in.tail0 = req_rx_byte;
         if (state_ff.byte_count != 7'(atp_pkg::COUNT_MAX)) begin
            state_in.byte_count = 7'(state_ff.byte_count + 7'd1);
         end
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in      = kind_ff;
      data_in      = data_ff;
      fields_in    = fields_ff;
      if (accept && is_cr) begin
         rsp_valid_in = 1'b1;
         kind_in      = atp_pkg::KIND_END;
         data_in      = 8'd0;
         fields_in    = end_result;
      end else if (accept && emit) begin
         rsp_valid_in = 1'b1;
         kind_in      = atp_pkg::KIND_DATA;
         data_in      = leaving;
         fields_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      data_ff   <= data_in;
      fields_ff <= fields_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_kind              = kind_ff;
   assign rsp_data_byte         = data_ff;
   assign rsp_station_addr      = fields_ff.station_addr;
   assign rsp_action_code       = fields_ff.action_code;
   assign rsp_param_index       = fields_ff.param_index;
   assign rsp_payload_len       = fields_ff.payload_len;
   assign rsp_received_checksum = fields_ff.received_checksum;
   assign rsp_parse_status      = fields_ff.parse_status;

endmodule
